>>> sv/pawt_pkg.sv
package pawt_pkg;

  localparam int unsigned SeqW    = 32;
  localparam int unsigned AckBits = 32;
  localparam int unsigned WinW    = AckBits + 1;
  localparam int unsigned StepW   = $clog2(AckBits + 1);

  typedef enum logic [1:0] {
    REQ_SEND  = 2'd0,
    REQ_RECV  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_QRD,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic accept;
    logic mark;
    logic qrd;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    req_e req;
    logic proto_ok;
    logic mark_last;
  } dp_sts_t;

endpackage

>>> sv/pawt_ctrl.sv
module pawt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  pawt_pkg::dp_sts_t   sts_i,
  output pawt_pkg::ctrl_cmd_t cmd_o
);

  pawt_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != pawt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pawt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      pawt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.req)
            pawt_pkg::REQ_RECV:  state_d = sts_i.proto_ok ? pawt_pkg::ST_MARK
                                                          : pawt_pkg::ST_PUSH;
            pawt_pkg::REQ_QUERY: state_d = pawt_pkg::ST_QRD;
            default:             state_d = pawt_pkg::ST_PUSH;
          endcase
        end
      end
      pawt_pkg::ST_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.mark_last) begin
          state_d = pawt_pkg::ST_PUSH;
        end
      end
      pawt_pkg::ST_QRD: begin
        cmd_o.qrd = 1'b1;
        state_d   = pawt_pkg::ST_PUSH;
      end
      pawt_pkg::ST_PUSH: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = pawt_pkg::ST_IDLE;
        end
      end
      default: state_d = pawt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

>>> sv/pawt_dp.sv
module pawt_dp #(
  parameter int unsigned SENT_WINDOW = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic [1:0]          req_type_i,
  input  logic [31:0]         rx_protocol_i,
  input  logic [31:0]         rx_sequence_i,
  input  logic [31:0]         rx_ack_i,
  input  logic [31:0]         rx_ack_bits_i,
  input  logic [31:0]         query_sequence_i,
  output logic                status_o,
  output logic [31:0]         tx_sequence_o,
  output logic [31:0]         tx_ack_o,
  output logic [31:0]         tx_ack_bits_o,
  output logic                query_acked_o,
  input  pawt_pkg::ctrl_cmd_t cmd_i,
  output pawt_pkg::dp_sts_t   sts_o
);

  localparam int unsigned PosW = $clog2(SENT_WINDOW);
  localparam int unsigned CntW = $clog2(SENT_WINDOW + 1);

  logic [31:0]                 protocol_q;
  logic [31:0]                 local_seq_q;
  logic [31:0]                 remote_q;
  logic [pawt_pkg::WinW-1:0]   recv_win_q;
  logic [PosW-1:0]             ring_pos_q;
  logic [CntW-1:0]             ring_cnt_q;
  logic [31:0]                 ack_q;
  logic [31:0]                 bits_q;
  logic [pawt_pkg::StepW-1:0]  step_q;
  logic                        qwin_q;
  logic                        rdata_q;

  logic                        mem [SENT_WINDOW];

  logic                        res_status_q;
  logic [31:0]                 res_tx_seq_q;
  logic [31:0]                 res_tx_ack_q;
  logic [31:0]                 res_tx_bits_q;
  logic                        res_acked_q;

  logic [31:0]                 mark_tgt;
  logic                        mark_en;
  logic                        mark_win;
  logic [PosW-1:0]             mark_slot;
  logic                        q_win;
  logic [PosW-1:0]             q_slot;
  logic                        mem_we;
  logic [PosW-1:0]             mem_wa;
  logic                        mem_wd;
  logic                        is_send;
  logic                        is_recv_ok;
  logic [31:0]                 fwd;
  logic [31:0]                 back;
  logic [pawt_pkg::WinW-1:0]   win_d;

  function automatic logic in_window(input logic [31:0] age, input logic [CntW-1:0] cnt);
    in_window = (age != 32'd0) && (age <= 32'(cnt));
  endfunction

  function automatic logic [PosW-1:0] slot_of(input logic [31:0] age,
                                             input logic [PosW-1:0] pos);
    logic [CntW-1:0] a;
    logic [CntW-1:0] p;
    logic [CntW-1:0] r;
    a = age[CntW-1:0];
    p = CntW'(pos);
    if (p >= a) begin
      r = p - a;
    end else begin
      r = p + CntW'(SENT_WINDOW) - a;
    end
    slot_of = r[PosW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;

  assign sts_o.req       = pawt_pkg::req_e'(req_type_i);
  assign sts_o.proto_ok  = (rx_protocol_i == protocol_q);
  assign sts_o.mark_last = (step_q == pawt_pkg::StepW'(pawt_pkg::AckBits));

  assign is_send    = cmd_i.accept && (sts_o.req == pawt_pkg::REQ_SEND);
  assign is_recv_ok = cmd_i.accept && (sts_o.req == pawt_pkg::REQ_RECV) && sts_o.proto_ok;

  assign mark_tgt  = ack_q - 32'(step_q);
  assign mark_en   = (step_q == '0) || bits_q[0];
  assign mark_win  = in_window(local_seq_q - mark_tgt, ring_cnt_q);
  assign mark_slot = slot_of(local_seq_q - mark_tgt, ring_pos_q);
  assign q_win     = in_window(local_seq_q - query_sequence_i, ring_cnt_q);
  assign q_slot    = slot_of(local_seq_q - query_sequence_i, ring_pos_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ring_pos_q;
    mem_wd = 1'b0;
    if (is_send) begin
      mem_we = 1'b1;
    end else if (cmd_i.mark && mark_en && mark_win) begin
      mem_we = 1'b1;
      mem_wa = mark_slot;
      mem_wd = 1'b1;
    end
  end

  always_comb begin
    fwd   = rx_sequence_i - remote_q;
    back  = remote_q - rx_sequence_i;
    win_d = recv_win_q;
    if (rx_sequence_i > remote_q) begin
      if (fwd <= 32'(pawt_pkg::AckBits)) begin
        win_d = (recv_win_q << fwd[pawt_pkg::StepW-1:0]) | pawt_pkg::WinW'(1);
      end else begin
        win_d = pawt_pkg::WinW'(1);
      end
    end else if (back <= 32'(pawt_pkg::AckBits)) begin
      win_d = recv_win_q | (pawt_pkg::WinW'(1) << back[pawt_pkg::StepW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol_q  <= '0;
      local_seq_q <= '0;
      remote_q    <= '0;
      recv_win_q  <= '0;
      ring_pos_q  <= '0;
      ring_cnt_q  <= '0;
      step_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        protocol_q <= cfg_data_i;
      end
      if (is_send) begin
        local_seq_q <= local_seq_q + 32'd1;
        ring_pos_q  <= (ring_pos_q == PosW'(SENT_WINDOW - 1)) ? '0 : ring_pos_q + PosW'(1);
        if (ring_cnt_q != CntW'(SENT_WINDOW)) begin
          ring_cnt_q <= ring_cnt_q + CntW'(1);
        end
      end
      if (is_recv_ok) begin
        recv_win_q <= win_d;
        if (rx_sequence_i > remote_q) begin
          remote_q <= rx_sequence_i;
        end
        step_q <= '0;
      end else if (cmd_i.mark) begin
        step_q <= step_q + pawt_pkg::StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[q_slot];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ack_q         <= rx_ack_i;
      bits_q        <= rx_ack_bits_i;
      qwin_q        <= q_win;
      res_status_q  <= (sts_o.req == pawt_pkg::REQ_RECV) && !sts_o.proto_ok;
      res_tx_seq_q  <= is_send ? local_seq_q : '0;
      res_tx_ack_q  <= is_send ? remote_q : '0;
      res_tx_bits_q <= is_send ? recv_win_q[pawt_pkg::AckBits:1] : '0;
      res_acked_q   <= 1'b0;
    end else begin
      if (cmd_i.mark && (step_q != '0)) begin
        bits_q <= bits_q >> 1;
      end
      if (cmd_i.qrd) begin
        res_acked_q <= qwin_q && rdata_q;
      end
    end
    if (cmd_i.push) begin
      status_o      <= res_status_q;
      tx_sequence_o <= res_tx_seq_q;
      tx_ack_o      <= res_tx_ack_q;
      tx_ack_bits_o <= res_tx_bits_q;
      query_acked_o <= res_acked_q;
    end
  end

endmodule

>>> sv/packet_ack_window_tracker.sv
// Header tracker for a sequenced datagram link with selective acknowledgment.
// Input channel (in_valid_i / in_stall_o) carries one request per transaction:
// send header, receive header or acknowledgment query. Output channel
// (out_valid_o / out_stall_i) returns one result transaction per request.
// The protocol id register is written through cfg_valid_i / cfg_data_i; it is
// always ready and must only be written while the block is idle.
// Each request goes from ST_IDLE to ST_PUSH, which loads the output
// register: send, rejected receive and unused codes directly; a query via
// ST_QRD (sent-ack memory read); an accepted receive via the mark loop
// (ST_MARK) that walks the ack number and its 32 bitmap bits through the
// single write port of the sent-ack memory, one entry per cycle. One request
// is processed at a time; the next is accepted once the last result is loaded.
// Reset clears sequences, the received window and the sent-ring count; the
// sent-ack memory needs no clearing since entries outside the count read as
// not acknowledged. A stalled result is held in the output register; the
// next request is accepted meanwhile and its result waits until it drains.
module packet_ack_window_tracker #(
  parameter int unsigned SENT_WINDOW = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] rx_protocol_i,
  input  logic [31:0] rx_sequence_i,
  input  logic [31:0] rx_ack_i,
  input  logic [31:0] rx_ack_bits_i,
  input  logic [31:0] query_sequence_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [31:0] tx_sequence_o,
  output logic [31:0] tx_ack_o,
  output logic [31:0] tx_ack_bits_o,
  output logic        query_acked_o
);

  pawt_pkg::ctrl_cmd_t cmd;
  pawt_pkg::dp_sts_t   sts;

  pawt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pawt_dp #(
    .SENT_WINDOW (SENT_WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .rx_protocol_i    (rx_protocol_i),
    .rx_sequence_i    (rx_sequence_i),
    .rx_ack_i         (rx_ack_i),
    .rx_ack_bits_i    (rx_ack_bits_i),
    .query_sequence_i (query_sequence_i),
    .status_o         (status_o),
    .tx_sequence_o    (tx_sequence_o),
    .tx_ack_o         (tx_ack_o),
    .tx_ack_bits_o    (tx_ack_bits_o),
    .query_acked_o    (query_acked_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a request is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> out_valid_o)
    else $error("result loaded but not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(status_o && query_acked_o))
    else $error("reject status and query ack on the same result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (tx_sequence_o == '0 && tx_ack_bits_o == '0))
    else $error("rejected receive carries send header fields");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SentWin = 64;
  localparam int SettleCycles = 40;
  localparam int PhaseItems = 230;
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] proto;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] bits;
    logic [31:0] qseq;
  } hdr_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [31:0] tx_bits;
    logic        acked;
  } hdr_result_t;

  class ack_window_model;
    logic [31:0] protocol;
    logic [31:0] local_seq;
    logic [31:0] remote_hi;
    logic [32:0] recv_win;
    bit          sent_acked [SentWin];
    int          ring_pos;
    int          ring_cnt;
    hdr_result_t expected_headers [$];
    int          mismatches;

    function new();
      protocol  = '0;
      local_seq = '0;
      remote_hi = '0;
      recv_win  = '0;
      ring_pos  = 0;
      ring_cnt  = 0;
      mismatches = 0;
      foreach (sent_acked[k]) sent_acked[k] = 1'b0;
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction

    function int sent_slot_of(logic [31:0] s);
      logic [31:0] age;
      age = local_seq - s;
      if (age == 0 || age > ring_cnt) return -1;
      return (ring_pos + SentWin - int'(age)) % SentWin;
    endfunction

    function void mark_sent_acked(logic [31:0] s);
      int k;
      k = sent_slot_of(s);
      if (k >= 0) sent_acked[k] = 1'b1;
    endfunction

    function void record_remote_seq(logic [31:0] s);
      logic [31:0] gap;
      if (s > remote_hi) begin
        gap = s - remote_hi;
        if (gap <= 32) recv_win = recv_win << gap;
        else recv_win = '0;
        recv_win[0] = 1'b1;
        remote_hi = s;
      end else begin
        gap = remote_hi - s;
        if (gap <= 32) recv_win[gap] = 1'b1;
      end
    endfunction

    function void take_request(hdr_req_t r);
      hdr_result_t res;
      int k;
      res = '0;
      case (r.req)
        pawt_pkg::REQ_SEND: begin
          res.tx_seq  = local_seq;
          res.tx_ack  = remote_hi;
          res.tx_bits = recv_win[32:1];
          sent_acked[ring_pos] = 1'b0;
          ring_pos = (ring_pos + 1) % SentWin;
          if (ring_cnt < SentWin) ring_cnt++;
          local_seq++;
        end
        pawt_pkg::REQ_RECV: begin
          if (r.proto != protocol) begin
            res.status = 1'b1;
          end else begin
            record_remote_seq(r.seq);
            mark_sent_acked(r.ack);
            for (int i = 0; i < 32; i++)
              if (r.bits[i]) mark_sent_acked(r.ack - 32'(i + 1));
          end
        end
        pawt_pkg::REQ_QUERY: begin
          k = sent_slot_of(r.qseq);
          res.acked = (k >= 0) && sent_acked[k];
        end
        default: ;
      endcase
      expected_headers = {expected_headers, res};
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(hdr_result_t got);
      hdr_result_t want;
      if (expected_headers.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_headers.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
        if (got.tx_seq !== want.tx_seq)
          report_mismatch($sformatf("tx_sequence %h, want %h", got.tx_seq, want.tx_seq));
        if (got.tx_ack !== want.tx_ack)
          report_mismatch($sformatf("tx_ack %h, want %h", got.tx_ack, want.tx_ack));
        if (got.tx_bits !== want.tx_bits)
          report_mismatch($sformatf("tx_ack_bits %h, want %h", got.tx_bits, want.tx_bits));
        if (got.acked !== want.acked)
          report_mismatch($sformatf("query_acked %0b, want %0b", got.acked, want.acked));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [1:0]  req_type = '0;
  logic [31:0] rx_protocol = '0;
  logic [31:0] rx_sequence = '0;
  logic [31:0] rx_ack = '0;
  logic [31:0] rx_ack_bits = '0;
  logic [31:0] query_sequence = '0;
  logic        out_stall = 1'b0;
  logic        quiet = 1'b0;

  wire         cfg_ready;
  wire         in_stall;
  wire         out_valid;
  wire         status;
  wire [31:0]  tx_sequence;
  wire [31:0]  tx_ack;
  wire [31:0]  tx_ack_bits;
  wire         query_acked;

  ack_window_model model = new();

  packet_ack_window_tracker #(
    .SENT_WINDOW(SentWin)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .rx_protocol_i   (rx_protocol),
    .rx_sequence_i   (rx_sequence),
    .rx_ack_i        (rx_ack),
    .rx_ack_bits_i   (rx_ack_bits),
    .query_sequence_i(query_sequence),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .tx_sequence_o   (tx_sequence),
    .tx_ack_o        (tx_ack),
    .tx_ack_bits_o   (tx_ack_bits),
    .query_acked_o   (query_acked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      model.check_result({status, tx_sequence, tx_ack, tx_ack_bits, query_acked});
    out_stall <= !quiet && ($urandom_range(99) < 34);
  end

  function automatic hdr_req_t hdr_req(logic [1:0] req, logic [31:0] proto,
                                       logic [31:0] seq, logic [31:0] ack,
                                       logic [31:0] bits, logic [31:0] qseq);
    hdr_req_t r;
    r = {req, proto, seq, ack, bits, qseq};
    return r;
  endfunction

  function automatic hdr_req_t make_request();
    hdr_req_t r;
    int pick;
    r = {2'd0, $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    pick = $urandom_range(99);
    if (pick < 28) r.req = pawt_pkg::REQ_SEND;
    else if (pick < 66) r.req = pawt_pkg::REQ_RECV;
    else if (pick < 94) r.req = pawt_pkg::REQ_QUERY;
    else r.req = ReqUnused;

    pick = $urandom_range(99);
    if (pick < 85) r.proto = model.protocol;
    else if (pick < 95) r.proto = model.protocol ^ (32'd1 << $urandom_range(31));

    pick = $urandom_range(99);
    if (pick < 45) r.seq = model.remote_hi + $urandom_range(1, 3);
    else if (pick < 75) r.seq = model.remote_hi - $urandom_range(0, 40);
    else if (pick < 88) r.seq = model.remote_hi + $urandom_range(4, 60);

    if ($urandom_range(99) < 80) r.ack = model.local_seq - $urandom_range(0, 70);

    pick = $urandom_range(99);
    if (pick < 35) r.bits = $urandom() & $urandom() & $urandom();
    else if (pick < 45) r.bits = '0;
    else if (pick < 50) r.bits = '1;

    if ($urandom_range(99) < 85) r.qseq = model.local_seq - $urandom_range(0, 72);
    return r;
  endfunction

  task automatic push_request(hdr_req_t r);
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= r.req;
    rx_protocol    <= r.proto;
    rx_sequence    <= r.seq;
    rx_ack         <= r.ack;
    rx_ack_bits    <= r.bits;
    query_sequence <= r.qseq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.take_request(r);
  endtask

  task automatic settle(int extra);
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_protocol(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model.protocol = value;
  endtask

  initial begin
    #5_000_000;
    $display("packet_ack_window_tracker verification failed");
    $finish;
  end

  initial begin
    logic [31:0] protos [5];
    int pause_at;

    protos = '{32'hFFFF_FFFF, $urandom(), 32'h0, $urandom(), 32'h8000_0001};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_request(hdr_req(pawt_pkg::REQ_QUERY, '0, '0, '0, '0, '0));
    push_request(hdr_req(ReqUnused, '1, '1, '1, '1, '1));
    push_request(hdr_req(pawt_pkg::REQ_SEND, '1, '1, '1, '1, '1));
    push_request(hdr_req(pawt_pkg::REQ_SEND, '0, '0, '0, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_SEND, '0, '0, '0, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '0, 32'd5, 32'd2, 32'h3, '0));
    for (int q = 0; q < 4; q++)
      push_request(hdr_req(pawt_pkg::REQ_QUERY, '0, '0, '0, '0, 32'(q)));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '1, '1, '1, '1, '1));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '0, 32'd100, 32'd1, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '0, 32'd50, '0, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '0, 32'd68, '0, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_SEND, '0, '0, '0, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '0, '1, '1, '1, '0));
    push_request(hdr_req(pawt_pkg::REQ_SEND, '0, '0, '0, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '0, '0, '0, '0, '0));
    push_request(hdr_req(pawt_pkg::REQ_QUERY, '0, '0, '0, '0, '1));
    settle(SettleCycles);
    set_protocol(32'hFFFF_FFFF);
    push_request(hdr_req(pawt_pkg::REQ_RECV, '1, 32'd3, 32'd4, '1, '0));
    push_request(hdr_req(pawt_pkg::REQ_RECV, '0, 32'd7, 32'd4, '1, '0));
    push_request(hdr_req(pawt_pkg::REQ_QUERY, '0, '0, '0, '0, 32'd3));
    push_request(hdr_req(pawt_pkg::REQ_SEND, '0, '0, '0, '0, '0));

    for (int ph = 0; ph < 5; ph++) begin
      settle(SettleCycles);
      set_protocol(protos[ph]);
      quiet = (ph == 2);
      pause_at = $urandom_range(20, 200);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == pause_at) settle(0);
        push_request(make_request());
      end
    end
    quiet = 1'b0;
    settle(SettleCycles);

    if (model.mismatches == 0 && model.pending() == 0)
      $display("packet_ack_window_tracker verification clean");
    else
      $display("packet_ack_window_tracker verification failed");
    $finish;
  end

endmodule

>>> files.f
sv/pawt_pkg.sv
sv/pawt_ctrl.sv
sv/pawt_dp.sv
sv/packet_ack_window_tracker.sv
tb/tb.sv
